// File: design/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and constants for the format spec parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsp_pkg;

    // Result count width (outputs saturate at the all-ones value of this width)
    localparam int OUT_BITS = 16;
    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

    // Default accumulator width
    localparam int COUNT_BITS_DEF = 16;

    localparam int CH_BITS   = 8;
    localparam int CONV_BITS = 4;

    // Characters of interest
    localparam logic [CH_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_BITS-1:0] CH_HASH  = 8'h23; // '#'
    localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30; // '0'
    localparam logic [CH_BITS-1:0] CH_ONE   = 8'h31; // '1'
    localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39; // '9'
    localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D; // '-'
    localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20; // ' '
    localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2B; // '+'
    localparam logic [CH_BITS-1:0] CH_DOT   = 8'h2E; // '.'
    localparam logic [CH_BITS-1:0] CH_PCT   = 8'h25; // '%'
    localparam logic [CH_BITS-1:0] CH_LC    = 8'h63; // 'c'
    localparam logic [CH_BITS-1:0] CH_LS    = 8'h73; // 's'
    localparam logic [CH_BITS-1:0] CH_LP    = 8'h70; // 'p'
    localparam logic [CH_BITS-1:0] CH_LD    = 8'h64; // 'd'
    localparam logic [CH_BITS-1:0] CH_LI    = 8'h69; // 'i'
    localparam logic [CH_BITS-1:0] CH_LU    = 8'h75; // 'u'
    localparam logic [CH_BITS-1:0] CH_LX    = 8'h78; // 'x'
    localparam logic [CH_BITS-1:0] CH_UX    = 8'h58; // 'X'

    // Conversion codes
    localparam logic [CONV_BITS-1:0] CONV_CHAR = 4'd0;
    localparam logic [CONV_BITS-1:0] CONV_STR  = 4'd1;
    localparam logic [CONV_BITS-1:0] CONV_PTR  = 4'd2;
    localparam logic [CONV_BITS-1:0] CONV_INT  = 4'd3;
    localparam logic [CONV_BITS-1:0] CONV_UNS  = 4'd4;
    localparam logic [CONV_BITS-1:0] CONV_LHEX = 4'd5;
    localparam logic [CONV_BITS-1:0] CONV_UHEX = 4'd6;
    localparam logic [CONV_BITS-1:0] CONV_PCT  = 4'd7;
    localparam logic [CONV_BITS-1:0] CONV_NONE = 4'd8;

    // Flag register bit positions
    localparam int FL_ALT   = 0;
    localparam int FL_ZERO  = 1;
    localparam int FL_LEFT  = 2;
    localparam int FL_BLANK = 3;
    localparam int FL_PLUS  = 4;
    localparam int FL_DOT   = 5;
    localparam int FL_BITS  = 6;

    // Digit run tracker
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RUN  = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    typedef struct packed {
        logic                 hit;
        logic [CONV_BITS-1:0] code;
    } conv_t;

    function automatic conv_t conv_lookup(input logic [CH_BITS-1:0] ch);
        conv_t r;
        r.hit  = 1'b1;
        r.code = CONV_NONE;
        case (ch)
            CH_LC:   r.code = CONV_CHAR;
            CH_LS:   r.code = CONV_STR;
            CH_LP:   r.code = CONV_PTR;
            CH_LD:   r.code = CONV_INT;
            CH_LI:   r.code = CONV_INT;
            CH_LU:   r.code = CONV_UNS;
            CH_LX:   r.code = CONV_LHEX;
            CH_UX:   r.code = CONV_UHEX;
            CH_PCT:  r.code = CONV_PCT;
            CH_NUL:  r.code = CONV_NONE;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: design/format_spec_parser.sv
// ----------------------------------------------------------------------------
// format_spec_parser
// Parses the characters after a percent sign and emits one conversion spec
// (flags, width, precision, conversion kind) per conversion character or NUL.
// ----------------------------------------------------------------------------
// Channel  | Dir | Bits          | Content
// s_*      | in  | tdata[7:0]    | ch, one format character per beat
// m_*      | out | tuser[3:0]    | conversion
//          |     | tdata[39:0]   | width, precision, six flag bits, 2 pad zeros
//
// One character per cycle, sustained unless the result stalls. Each character
// is registered, then the parse step (compare plus multiply-by-ten accumulate)
// updates the state and, on a conversion character, loads the result register.
// A stalled result blocks the parse step only; the input register still takes
// one more beat. Reset clears all parse state and both valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module format_spec_parser #(
    parameter int COUNT_BITS = fsp_pkg::COUNT_BITS_DEF  // 8..32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [3:0]  m_tuser,    // [3:0] conversion
    output logic [39:0] m_tdata     // [15:0] min_width, [31:16] precision_value,
                                    // [32] alt_form, [33] zero_pad,
                                    // [34] left_justify, [35] blank_sign,
                                    // [36] plus_sign, [37] precision_given, [39:38] 0
);
    import fsp_pkg::*;

    localparam int ACC_W    = COUNT_BITS + 4;
    localparam int EXT_BITS = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

    // acc*10 + d with saturation at all ones
    function automatic logic [COUNT_BITS-1:0] acc_digit(
        input logic [COUNT_BITS-1:0] acc,
        input logic [3:0]            d
    );
        logic [ACC_W-1:0] v;
        v = ACC_W'({acc, 3'b000}) + ACC_W'({acc, 1'b0}) + ACC_W'(d);
        return (|v[ACC_W-1:COUNT_BITS]) ? {COUNT_BITS{1'b1}} : v[COUNT_BITS-1:0];
    endfunction

    function automatic logic [OUT_BITS-1:0] clip_out(input logic [COUNT_BITS-1:0] acc);
        logic [EXT_BITS-1:0] e;
        e = EXT_BITS'(acc);
        return (e > EXT_BITS'(OUT_MAX)) ? OUT_MAX : e[OUT_BITS-1:0];
    endfunction

    // Input register
    logic               in_valid_reg;
    logic [CH_BITS-1:0] ch_reg;
    logic               proc_fire;

    // Parse state
    logic [FL_BITS-1:0]    flags_reg, flags_next;
    logic                  digit_seen_reg, digit_seen_next;
    logic [COUNT_BITS-1:0] width_acc_reg, width_acc_next;
    phase_t                width_phase_reg, width_phase_next;
    logic [COUNT_BITS-1:0] prec_acc_reg, prec_acc_next;
    phase_t                prec_phase_reg, prec_phase_next;

    // Result register
    logic                 out_valid_reg;
    logic [CONV_BITS-1:0] conv_reg, conv_next;
    logic [39:0]          data_reg, data_next;

    conv_t            conv;
    logic             is_digit;
    logic             is_nz_digit;
    logic [3:0]       dval;
    logic             zp, bl;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ch_reg <= s_tdata;
        end
    end

    // Parse step
    always_comb
    begin
        conv        = conv_lookup(ch_reg);
        is_digit    = ch_reg inside {[CH_ZERO:CH_NINE]};
        is_nz_digit = ch_reg inside {[CH_ONE:CH_NINE]};
        dval        = 4'(ch_reg - CH_ZERO);

        flags_next       = flags_reg;
        digit_seen_next  = digit_seen_reg;
        width_acc_next   = width_acc_reg;
        width_phase_next = width_phase_reg;
        prec_acc_next    = prec_acc_reg;
        prec_phase_next  = prec_phase_reg;

        // override rules applied at emission
        zp = flags_reg[FL_ZERO];
        bl = flags_reg[FL_BLANK];
        if ((flags_reg[FL_DOT] && (conv.code inside {[CONV_INT:CONV_UHEX]}))
            || flags_reg[FL_LEFT])
        begin
            zp = 1'b0;
        end
        if (flags_reg[FL_PLUS])
        begin
            bl = 1'b0;
        end
        conv_next = conv.code;
        data_next = {2'b00, flags_reg[FL_DOT], flags_reg[FL_PLUS], bl,
                     flags_reg[FL_LEFT], zp, flags_reg[FL_ALT],
                     clip_out(prec_acc_reg), clip_out(width_acc_reg)};

        if (proc_fire)
        begin
            if (conv.hit)
            begin
                flags_next       = '0;
                digit_seen_next  = 1'b0;
                width_acc_next   = '0;
                width_phase_next = PH_IDLE;
                prec_acc_next    = '0;
                prec_phase_next  = PH_IDLE;
            end
            else
            begin
                if (is_nz_digit)
                    digit_seen_next = 1'b1;
                if (ch_reg == CH_HASH)
                    flags_next[FL_ALT] = 1'b1;
                if (ch_reg == CH_ZERO && !digit_seen_reg)
                    flags_next[FL_ZERO] = 1'b1;
                if (ch_reg == CH_MINUS)
                    flags_next[FL_LEFT] = 1'b1;
                if (ch_reg == CH_SPACE)
                    flags_next[FL_BLANK] = 1'b1;
                if (ch_reg == CH_PLUS)
                    flags_next[FL_PLUS] = 1'b1;
                if (ch_reg == CH_DOT)
                    flags_next[FL_DOT] = 1'b1;

                // width: first nonzero-led run before any dot
                if (width_phase_reg == PH_RUN)
                begin
                    if (is_digit)
                        width_acc_next = acc_digit(width_acc_reg, dval);
                    else
                        width_phase_next = PH_DONE;
                end
                else if (width_phase_reg == PH_IDLE && prec_phase_reg == PH_IDLE
                         && is_nz_digit)
                begin
                    width_acc_next   = COUNT_BITS'(dval);
                    width_phase_next = PH_RUN;
                end

                // precision: run right after the first dot
                if (prec_phase_reg == PH_RUN)
                begin
                    if (is_digit)
                        prec_acc_next = acc_digit(prec_acc_reg, dval);
                    else
                        prec_phase_next = PH_DONE;
                end
                else if (prec_phase_reg == PH_IDLE && ch_reg == CH_DOT)
                begin
                    prec_acc_next   = '0;
                    prec_phase_next = PH_RUN;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg       <= '0;
            digit_seen_reg  <= 1'b0;
            width_acc_reg   <= '0;
            width_phase_reg <= PH_IDLE;
            prec_acc_reg    <= '0;
            prec_phase_reg  <= PH_IDLE;
        end
        else
        begin
            flags_reg       <= flags_next;
            digit_seen_reg  <= digit_seen_next;
            width_acc_reg   <= width_acc_next;
            width_phase_reg <= width_phase_next;
            prec_acc_reg    <= prec_acc_next;
            prec_phase_reg  <= prec_phase_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire && conv.hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && conv.hit)
        begin
            conv_reg <= conv_next;
            data_reg <= data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = conv_reg;
    assign m_tdata  = data_reg;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && conv.hit) |=> (flags_reg == '0 && !digit_seen_reg
            && width_phase_reg == PH_IDLE && prec_phase_reg == PH_IDLE))
        else $error("parse state not cleared after emit");

    a_width_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (width_phase_reg != PH_IDLE) |-> digit_seen_reg)
        else $error("width run without a nonzero digit");

    a_blank_plus: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[35] && m_tdata[36]))
        else $error("blank and plus both set");

    a_zero_left: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[33] && m_tdata[34]))
        else $error("zero pad and left justify both set");

endmodule
